[hdl/srt_pkg.sv]
`timescale 1ns / 1ps

package srt_pkg;

    // operation codes
    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_REMOVE = 3'd1;
    localparam logic [2:0] FUNC_CHANGE = 3'd2;
    localparam logic [2:0] FUNC_QUERY  = 3'd3;
    localparam logic [2:0] FUNC_LIST   = 3'd4;

    // result status codes
    localparam logic [3:0] ST_INSTALLED     = 4'd0;
    localparam logic [3:0] ST_EXISTS        = 4'd1;
    localparam logic [3:0] ST_REMOVED       = 4'd2;
    localparam logic [3:0] ST_NOT_INSTALLED = 4'd3;
    localparam logic [3:0] ST_CHANGED       = 4'd4;
    localparam logic [3:0] ST_REPORT        = 4'd5;
    localparam logic [3:0] ST_LIST_ENTRY    = 4'd6;
    localparam logic [3:0] ST_EMPTY         = 4'd7;
    localparam logic [3:0] ST_FULL          = 4'd8;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] current;
        logic [15:0] voltage;
        logic [15:0] eff;
        logic [31:0] power;
    } t_rec;

endpackage

[hdl/srt_mem.sv]
`timescale 1ns / 1ps

module srt_mem #(
    parameter int TABLE_DEPTH = 64,
    parameter int AW          = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  srt_pkg::t_rec i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output srt_pkg::t_rec o_rd_data
);

    srt_pkg::t_rec r_mem [TABLE_DEPTH];
    srt_pkg::t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/srt_ctrl.sv]
`timescale 1ns / 1ps

module srt_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int AW          = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [2:0]    i_func,
    input  logic [15:0]   i_sensor_id,
    input  logic [15:0]   i_current,
    input  logic [15:0]   i_voltage,
    input  logic [15:0]   i_efficiency,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [3:0]    o_status,
    output logic [15:0]   o_rec_id,
    output logic [31:0]   o_rec_power,
    output logic [15:0]   o_rec_efficiency,
    output logic          o_last,
    output logic          o_mem_wr_en,
    output logic [AW-1:0] o_mem_wr_addr,
    output srt_pkg::t_rec o_mem_wr_data,
    output logic          o_mem_rd_en,
    output logic [AW-1:0] o_mem_rd_addr,
    input  srt_pkg::t_rec i_mem_rd_data
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_QRD   = 3'd3;
    localparam logic [2:0] S_LIST  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic          r_chk_vld, n_chk_vld;
    logic [AW-1:0] r_chk_idx, n_chk_idx;
    logic [3:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;

    logic [2:0]    r_func;
    srt_pkg::t_rec r_new;

    logic [3:0]    r_o_status, n_o_status;
    logic [15:0]   r_o_id, n_o_id;
    logic [31:0]   r_o_power, n_o_power;
    logic [15:0]   r_o_eff, n_o_eff;
    logic          r_o_last, n_o_last;

    logic          out_free;
    logic          hit;
    logic          emit;
    logic          emit_ok;
    logic          list_last;
    logic [3:0]    e_status;
    srt_pkg::t_rec e_rec;
    logic          e_last;

    assign out_free  = !r_out_valid || i_out_ready;
    assign hit       = r_chk_vld && (i_mem_rd_data.key == r_new.key);
    assign list_last = ((CW'(r_chk_idx) + CW'(1)) == r_fill);
    assign emit_ok   = r_chk_vld && out_free;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_rd_idx    = r_rd_idx;
        n_chk_vld   = r_chk_vld;
        n_chk_idx   = r_chk_idx;
        n_status    = r_status;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_chk_idx;
        o_mem_wr_data = r_new;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_rd_idx[AW-1:0];
        emit     = 1'b0;
        e_status = r_status;
        e_rec    = '0;
        e_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rd_idx  = '0;
                    n_chk_vld = 1'b0;
                    if (i_func == srt_pkg::FUNC_LIST) begin
                        if (r_fill == '0) begin
                            n_status = srt_pkg::ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_LIST;
                        end
                    end else if (i_func <= srt_pkg::FUNC_QUERY) begin
                        n_state = S_SRCH;
                    end
                end
            end

            S_SRCH: begin
                if (hit) begin
                    unique case (r_func)
                        srt_pkg::FUNC_INSERT: begin
                            n_status = srt_pkg::ST_EXISTS;
                            n_state  = S_FIN;
                        end
                        srt_pkg::FUNC_CHANGE: begin
                            o_mem_wr_en   = 1'b1;
                            o_mem_wr_addr = r_chk_idx;
                            n_status      = srt_pkg::ST_CHANGED;
                            n_state       = S_FIN;
                        end
                        srt_pkg::FUNC_QUERY: begin
                            o_mem_rd_en   = 1'b1;
                            o_mem_rd_addr = r_chk_idx;
                            n_state       = S_QRD;
                        end
                        default: begin
                            // remove: pull every later record down one slot
                            n_rd_idx  = CW'(r_chk_idx) + CW'(1);
                            n_chk_vld = 1'b0;
                            n_state   = S_SHIFT;
                        end
                    endcase
                end else if (r_rd_idx < r_fill) begin
                    o_mem_rd_en = 1'b1;
                    n_chk_idx   = r_rd_idx[AW-1:0];
                    n_rd_idx    = r_rd_idx + CW'(1);
                    n_chk_vld   = 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                    if (!r_chk_vld) begin
                        n_state = S_FIN;
                        if (r_func == srt_pkg::FUNC_INSERT) begin
                            if (r_fill >= CW'(TABLE_DEPTH)) begin
                                n_status = srt_pkg::ST_FULL;
                            end else begin
                                o_mem_wr_en   = 1'b1;
                                o_mem_wr_addr = r_fill[AW-1:0];
                                n_fill        = r_fill + CW'(1);
                                n_status      = srt_pkg::ST_INSTALLED;
                            end
                        end else begin
                            n_status = srt_pkg::ST_NOT_INSTALLED;
                        end
                    end
                end
            end

            S_SHIFT: begin
                // write slot k-1 while reading slot k+1
                if (r_chk_vld) begin
                    o_mem_wr_en   = 1'b1;
                    o_mem_wr_addr = r_chk_idx - AW'(1);
                    o_mem_wr_data = i_mem_rd_data;
                end
                if (r_rd_idx < r_fill) begin
                    o_mem_rd_en = 1'b1;
                    n_chk_idx   = r_rd_idx[AW-1:0];
                    n_rd_idx    = r_rd_idx + CW'(1);
                    n_chk_vld   = 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                    if (!r_chk_vld) begin
                        n_fill   = r_fill - CW'(1);
                        n_status = srt_pkg::ST_REMOVED;
                        n_state  = S_FIN;
                    end
                end
            end

            S_QRD: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_status = srt_pkg::ST_REPORT;
                    e_rec    = i_mem_rd_data;
                    n_state  = S_IDLE;
                end
            end

            S_LIST: begin
                // the read data register doubles as a one-entry buffer
                if (emit_ok) begin
                    emit     = 1'b1;
                    e_status = srt_pkg::ST_LIST_ENTRY;
                    e_rec    = i_mem_rd_data;
                    e_last   = list_last;
                end
                if ((r_rd_idx < r_fill) && (!r_chk_vld || emit_ok)) begin
                    o_mem_rd_en = 1'b1;
                    n_chk_idx   = r_rd_idx[AW-1:0];
                    n_rd_idx    = r_rd_idx + CW'(1);
                    n_chk_vld   = 1'b1;
                end else if (emit_ok) begin
                    n_chk_vld = 1'b0;
                    if (list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_FIN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_id      = r_o_id;
        n_o_power   = r_o_power;
        n_o_eff     = r_o_eff;
        n_o_last    = r_o_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_o_status  = e_status;
            n_o_id      = e_rec.key;
            n_o_power   = e_rec.power;
            n_o_eff     = e_rec.eff;
            n_o_last    = e_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_rd_idx    <= n_rd_idx;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx  <= n_chk_idx;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_id     <= n_o_id;
        r_o_power  <= n_o_power;
        r_o_eff    <= n_o_eff;
        r_o_last   <= n_o_last;
        if (i_in_valid && o_in_ready) begin
            r_func        <= i_func;
            r_new.key     <= i_sensor_id;
            r_new.current <= i_current;
            r_new.voltage <= i_voltage;
            r_new.eff     <= i_efficiency;
            r_new.power   <= 32'(i_current) * 32'(i_voltage);
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_rec_id         = r_o_id;
    assign o_rec_power      = r_o_power;
    assign o_rec_efficiency = r_o_eff;
    assign o_last           = r_o_last;

endmodule

[hdl/sensor_record_table_unit.sv]
`timescale 1ns / 1ps

// Ordered table of up to TABLE_DEPTH sensor records kept in one single-port-read,
// single-port-write memory with registered read data. One request is handled at a
// time and the next is taken as soon as the last result of the current one is in
// the output register. Insert, change and query scan the stored records from
// slot 0 at one slot per cycle; remove scans and then shifts the later records
// down at one per cycle; list streams one entry per cycle, slowed only by
// back-pressure. Power is formed as current times voltage when the request is
// taken. Unused operation codes give no result.
module sensor_record_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_sensor_id,
    input  logic [15:0] i_current,
    input  logic [15:0] i_voltage,
    input  logic [15:0] i_efficiency,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_status,
    output logic [15:0] o_rec_id,
    output logic [31:0] o_rec_power,
    output logic [15:0] o_rec_efficiency,
    output logic        o_last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    srt_pkg::t_rec mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    srt_pkg::t_rec mem_rd_data;

    srt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_sensor_id      (i_sensor_id),
        .i_current        (i_current),
        .i_voltage        (i_voltage),
        .i_efficiency     (i_efficiency),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_rec_id         (o_rec_id),
        .o_rec_power      (o_rec_power),
        .o_rec_efficiency (o_rec_efficiency),
        .o_last           (o_last),
        .o_mem_wr_en      (mem_wr_en),
        .o_mem_wr_addr    (mem_wr_addr),
        .o_mem_wr_data    (mem_wr_data),
        .o_mem_rd_en      (mem_rd_en),
        .o_mem_rd_addr    (mem_rd_addr),
        .i_mem_rd_data    (mem_rd_data)
    );

    srt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

endmodule
